// ===== rtl/quaternion_vertex_rotate_macros.svh =====
// Assertion macros shared by the quaternion vertex rotate RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef QUATERNION_VERTEX_ROTATE_MACROS_SVH
`define QUATERNION_VERTEX_ROTATE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold at the delay n after the antecedent.
`define QVR_ASSERT_DELAYED(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

// The expression must never be true outside reset.
`define QVR_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/qvr_pkg.sv =====
// Types and constants for the quaternion vertex rotate block.
// Used by qvr_matrix, qvr_row and the top level; depends on nothing.
package qvr_pkg;

	localparam int COORD_W = 32;
	localparam int QUAT_W  = 16;
	localparam int ENTRY_W = 32;
	localparam int ACC_W   = 64;
	localparam int FRAC_SH = 28;

	typedef logic signed [QUAT_W-1:0]  quat_comp_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		quat_comp_t s;
		quat_comp_t x;
		quat_comp_t y;
		quat_comp_t z;
	} quat_t;

	// Row-major 3x3 rotation matrix, entries in Q.28.
	typedef entry_t [8:0] mat_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_QUAT_S   = 3'd0;
	localparam logic [2:0] REG_QUAT_X   = 3'd1;
	localparam logic [2:0] REG_QUAT_Y   = 3'd2;
	localparam logic [2:0] REG_QUAT_Z   = 3'd3;
	localparam logic [2:0] REG_CENTRE_X = 3'd4;
	localparam logic [2:0] REG_CENTRE_Y = 3'd5;
	localparam logic [2:0] REG_CENTRE_Z = 3'd6;

	localparam quat_comp_t QUAT_ONE = 16'sd16384;
	localparam quat_t QUAT_RESET = '{s: QUAT_ONE, x: '0, y: '0, z: '0};

	localparam entry_t ENTRY_ONE = 32'sd268435456;   // 1.0 in Q.28
	localparam entry_t ENTRY_LIM = 32'sd1073741824;  // 4.0 in Q.28
	localparam acc_t   ROUND_HALF = 64'sd134217728;  // 0.5 ulp of the output

	localparam coord_t COORD_MAX = 32'sh7fffffff;
	localparam coord_t COORD_MIN = 32'sh80000000;

endpackage

// ===== rtl/qvr_matrix.sv =====
// Builds the rotation matrix from the quaternion registers in two register stages.
// Depends on qvr_pkg.
module qvr_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  qvr_pkg::quat_t quat,
	output qvr_pkg::mat_t  mat
);

	localparam int RAW_W = 35;

	// Products of quaternion components, Q.28: xx yy zz xy xz yz sx sy sz.
	logic signed [31:0] prod_d [9];
	logic signed [31:0] prod_q [9];
	logic signed [RAW_W-1:0] raw [9];
	qvr_pkg::mat_t mat_d;
	qvr_pkg::mat_t mat_q;

	always_comb begin
		prod_d[0] = 32'(quat.x) * 32'(quat.x);
		prod_d[1] = 32'(quat.y) * 32'(quat.y);
		prod_d[2] = 32'(quat.z) * 32'(quat.z);
		prod_d[3] = 32'(quat.x) * 32'(quat.y);
		prod_d[4] = 32'(quat.x) * 32'(quat.z);
		prod_d[5] = 32'(quat.y) * 32'(quat.z);
		prod_d[6] = 32'(quat.s) * 32'(quat.x);
		prod_d[7] = 32'(quat.s) * 32'(quat.y);
		prod_d[8] = 32'(quat.s) * 32'(quat.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				prod_q[i] <= '0;
			end
		end else begin
			prod_q <= prod_d;
		end
	end

	always_comb begin
		logic signed [RAW_W-1:0] one;
		logic signed [RAW_W-1:0] t [9];
		one = RAW_W'(qvr_pkg::ENTRY_ONE);
		for (int i = 0; i < 9; i++) begin
			t[i] = RAW_W'(prod_q[i]) <<< 1;
		end
		raw[0] = one - t[1] - t[2];
		raw[1] = t[3] - t[8];
		raw[2] = t[4] + t[7];
		raw[3] = t[3] + t[8];
		raw[4] = one - t[0] - t[2];
		raw[5] = t[5] - t[6];
		raw[6] = t[4] - t[7];
		raw[7] = t[5] + t[6];
		raw[8] = one - t[0] - t[1];
		for (int i = 0; i < 9; i++) begin
			if (raw[i] > RAW_W'(qvr_pkg::ENTRY_LIM)) begin
				mat_d[i] = qvr_pkg::ENTRY_LIM;
			end else if (raw[i] < -RAW_W'(qvr_pkg::ENTRY_LIM)) begin
				mat_d[i] = -qvr_pkg::ENTRY_LIM;
			end else begin
				mat_d[i] = raw[i][qvr_pkg::ENTRY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '{0: qvr_pkg::ENTRY_ONE, 4: qvr_pkg::ENTRY_ONE,
				8: qvr_pkg::ENTRY_ONE, default: '0};
		end else begin
			mat_q <= mat_d;
		end
	end

	assign mat = mat_q;

endmodule

// ===== rtl/qvr_row.sv =====
// One output coordinate: dot product of a matrix row with the vertex, plus centre,
// rounded and saturated over three register stages. Depends on qvr_pkg.
module qvr_row (
	input  logic            clk,
	input  qvr_pkg::entry_t m0,
	input  qvr_pkg::entry_t m1,
	input  qvr_pkg::entry_t m2,
	input  qvr_pkg::coord_t v_x,
	input  qvr_pkg::coord_t v_y,
	input  qvr_pkg::coord_t v_z,
	input  qvr_pkg::coord_t centre,
	output qvr_pkg::coord_t cur
);

	qvr_pkg::acc_t p0_s3, p1_s3, p2_s3;
	qvr_pkg::acc_t pair_s4, rest_s4;
	qvr_pkg::acc_t acc;
	qvr_pkg::acc_t centre_ext;
	qvr_pkg::coord_t cur_d;
	qvr_pkg::coord_t cur_s5;

	// Three signed products land in the 64-bit result width.
	always_ff @(posedge clk) begin
		p0_s3 <= qvr_pkg::acc_t'(m0) * qvr_pkg::acc_t'(v_x);
		p1_s3 <= qvr_pkg::acc_t'(m1) * qvr_pkg::acc_t'(v_y);
		p2_s3 <= qvr_pkg::acc_t'(m2) * qvr_pkg::acc_t'(v_z);
	end

	assign centre_ext = qvr_pkg::acc_t'(centre) <<< qvr_pkg::FRAC_SH;

	always_ff @(posedge clk) begin
		pair_s4 <= p0_s3 + p1_s3;
		rest_s4 <= p2_s3 + centre_ext + qvr_pkg::ROUND_HALF;
	end

	// Magnitudes stay below 2^63, so the 64-bit sum cannot wrap.
	assign acc = pair_s4 + rest_s4;

	always_comb begin
		if (acc[63:59] == {5{acc[59]}}) begin
			cur_d = acc[59:28];
		end else if (acc[63]) begin
			cur_d = qvr_pkg::COORD_MIN;
		end else begin
			cur_d = qvr_pkg::COORD_MAX;
		end
	end

	always_ff @(posedge clk) begin
		cur_s5 <= cur_d;
	end

	assign cur = cur_s5;

endmodule

// ===== rtl/quaternion_vertex_rotate.sv =====
// Top level of the quaternion vertex rotate block: configuration registers,
// valid pipeline and three row units. Depends on qvr_pkg, qvr_matrix, qvr_row.
//
// Usage:
// Write the quaternion (Q1.14) and the centroid (Q16.16) through cfg_we, cfg_idx
// and cfg_data; each write lands at the clock edge where cfg_we is high. Writes
// to index 7 are dropped. Configure only while no vertex is in flight.
// A vertex transfer happens at each edge where start is high and busy is low.
// busy is never raised: the pipeline takes one vertex every cycle.
// Each vertex gives one result after the vertex and row register stages: done is high for
// exactly one cycle with cur_x, cur_y, cur_z and last_out. The receiver cannot
// stall, so results are never held.
// The matrix is rebuilt from the registers in two stages; a vertex waits one
// extra stage after capture, so a vertex issued the cycle after a write sees it.
// Reset loads the identity quaternion and a zero centroid and empties the
// pipeline; no clearing pass is needed.
`include "quaternion_vertex_rotate_macros.svh"

module quaternion_vertex_rotate (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [31:0]           cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  qvr_pkg::coord_t       ref_x,
	input  qvr_pkg::coord_t       ref_y,
	input  qvr_pkg::coord_t       ref_z,
	input  logic                  last_vertex,
	output logic                  done,
	output qvr_pkg::coord_t       cur_x,
	output qvr_pkg::coord_t       cur_y,
	output qvr_pkg::coord_t       cur_z,
	output logic                  last_out
);

	qvr_pkg::quat_t  quat_q;
	qvr_pkg::coord_t centre_x_q, centre_y_q, centre_z_q;
	qvr_pkg::mat_t   mat;
	logic            take;

	logic [5:1] valid;
	logic [5:1] last;
	qvr_pkg::coord_t ref_x_s1, ref_y_s1, ref_z_s1;
	qvr_pkg::coord_t ref_x_s2, ref_y_s2, ref_z_s2;

	assign busy = 1'b0;
	assign take = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q     <= qvr_pkg::QUAT_RESET;
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				qvr_pkg::REG_QUAT_S:   quat_q.s   <= cfg_data[15:0];
				qvr_pkg::REG_QUAT_X:   quat_q.x   <= cfg_data[15:0];
				qvr_pkg::REG_QUAT_Y:   quat_q.y   <= cfg_data[15:0];
				qvr_pkg::REG_QUAT_Z:   quat_q.z   <= cfg_data[15:0];
				qvr_pkg::REG_CENTRE_X: centre_x_q <= cfg_data;
				qvr_pkg::REG_CENTRE_Y: centre_y_q <= cfg_data;
				qvr_pkg::REG_CENTRE_Z: centre_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qvr_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat_q),
		.mat    (mat)
	);

	// Valid and last-vertex flags travel alongside the data stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= '0;
			last  <= '0;
		end else begin
			valid <= {valid[4:1], take};
			last  <= {last[4:1], last_vertex};
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ref_x_s1 <= ref_x;
			ref_y_s1 <= ref_y;
			ref_z_s1 <= ref_z;
		end
		ref_x_s2 <= ref_x_s1;
		ref_y_s2 <= ref_y_s1;
		ref_z_s2 <= ref_z_s1;
	end

	qvr_row u_row_x (
		.clk    (clk),
		.m0     (mat[0]),
		.m1     (mat[1]),
		.m2     (mat[2]),
		.v_x    (ref_x_s2),
		.v_y    (ref_y_s2),
		.v_z    (ref_z_s2),
		.centre (centre_x_q),
		.cur    (cur_x)
	);

	qvr_row u_row_y (
		.clk    (clk),
		.m0     (mat[3]),
		.m1     (mat[4]),
		.m2     (mat[5]),
		.v_x    (ref_x_s2),
		.v_y    (ref_y_s2),
		.v_z    (ref_z_s2),
		.centre (centre_y_q),
		.cur    (cur_y)
	);

	qvr_row u_row_z (
		.clk    (clk),
		.m0     (mat[6]),
		.m1     (mat[7]),
		.m2     (mat[8]),
		.v_x    (ref_x_s2),
		.v_y    (ref_y_s2),
		.v_z    (ref_z_s2),
		.centre (centre_z_q),
		.cur    (cur_z)
	);

	assign done     = valid[5];
	assign last_out = last[5];

	`QVR_ASSERT_DELAYED(a_latency, take, 5, done, "transfer did not give a result after five cycles")
	`QVR_ASSERT_NEVER(a_no_spurious, done && !$past(take, 5), "result without a matching transfer")
	`QVR_ASSERT_IMPLY(a_last_flag, done, last_out == $past(last_vertex, 5), "last flag not carried")
	`QVR_ASSERT_IMPLY(a_identity, $past(quat_q == qvr_pkg::QUAT_RESET, 2), (mat[0] == qvr_pkg::ENTRY_ONE) && (mat[4] == qvr_pkg::ENTRY_ONE) && (mat[8] == qvr_pkg::ENTRY_ONE) && (mat[1] == '0) && (mat[5] == '0), "identity quaternion gave a non-identity matrix")

endmodule
